FILE: rtl/core/cbf_pkg.sv
// Shared constants, types and operation codes of the cubic Bezier flattener.
package cbf_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;
    localparam int FIELD_WIDTH         = 16;
    localparam int TERM_WIDTH          = 64;
    localparam int THR_WIDTH           = 66;
    localparam int LIMIT_WIDTH         = 32;
    localparam int STEP_WIDTH          = 32;
    localparam int SHIFT_WIDTH         = 6;
    localparam int CFG_INDEX_WIDTH     = 1;

    localparam int POS_SHIFT  = 10;
    localparam int DIFF_SHIFT = 11;
    localparam int POINT_FRAC = 13;
    localparam int ROUND_BIAS = 4096;

    localparam logic [SHIFT_WIDTH-1:0] LAZY_SHIFT_MAX  = 6'd32;
    localparam logic [SHIFT_WIDTH-1:0] LAZY_SHIFT_STEP = 6'd2;
    localparam logic [SHIFT_WIDTH-1:0] STEADY_SHIFT    = 6'd3;

    localparam logic [LIMIT_WIDTH-1:0] INITIAL_LIMIT_RESET = 32'd24576;
    localparam logic [LIMIT_WIDTH-1:0] RUNNING_LIMIT_RESET = 32'd196608;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INITIAL_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RUNNING_LIMIT = 1'b1;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    typedef logic signed [TERM_WIDTH-1:0] term_t;
    typedef logic signed [THR_WIDTH-1:0]  thr_t;

    typedef struct packed {
        term_t d0;
        term_t d1;
        term_t d2;
        term_t d3;
    } terms_t;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_INIT,
        OP_LAZY_A,
        OP_LAZY_B,
        OP_STEADY,
        OP_STEP,
        OP_HALVE_A,
        OP_HALVE_B,
        OP_DOUBLE
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [SHIFT_WIDTH-1:0] shift;
    } unit_ctrl_t;

endpackage

FILE: rtl/core/cbf_if.sv
// Handshake channels of the cubic Bezier flattener: curve input, point output, configuration.
interface cbf_curve_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     action;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] p0_x;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] p0_y;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] p1_x;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] p1_y;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] p2_x;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] p2_y;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] p3_x;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] p3_y;

    modport source (
        output valid, action, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        input  ready
    );
    modport sink (
        input  valid, action, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        output ready
    );
endinterface

interface cbf_point_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] point_x;
    logic signed [cbf_pkg::FIELD_WIDTH-1:0] point_y;
    logic                                     is_last;

    modport source (output valid, point_x, point_y, is_last, input ready);
    modport sink (input valid, point_x, point_y, is_last, output ready);
endinterface

interface cbf_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [cbf_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [cbf_pkg::LIMIT_WIDTH-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cubic_bezier_flattener.sv
// Top level of the cubic Bezier flattener: sequencer, term registers and handshakes.
//
// A load item (action 0) takes four control points and, after setting up the
// difference terms, returns the start point; each step item (action 1) returns the
// next polyline point, the curve end point flagged by is_last, and no item is
// returned for a step with no curve loaded. All term arithmetic goes through one
// shared unit that handles one axis per cycle, so the block takes one item at a
// time: a load finds the origin, sets up the terms and halves the step up to 16
// times (the initial step halvings) before its point is offered; a step checks the
// terms, halves the step if needed, tries doublings and then advances, and the
// final point of a curve goes to the output without any term work. The
// next item is accepted as soon as the sequencer is back in idle, even while the
// previous point still waits in the output register.
module cubic_bezier_flattener #(
    parameter int COORD_WIDTH = cbf_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    cbf_cfg_if.sink     cfg,
    cbf_curve_if.sink   curve,
    cbf_point_if.source point
);
    import cbf_pkg::*;

    localparam int RND_WIDTH = POINT_FRAC + COORD_WIDTH;

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_ORIGIN  = 15'h0002,
        S_INIT    = 15'h0004,
        S_LCHK    = 15'h0008,
        S_LAZY_A  = 15'h0010,
        S_LAZY_B  = 15'h0020,
        S_STEADY  = 15'h0040,
        S_STEP    = 15'h0080,
        S_RCHK    = 15'h0100,
        S_HALVE_A = 15'h0200,
        S_HALVE_B = 15'h0400,
        S_DTEST   = 15'h0800,
        S_DOUBLE  = 15'h1000,
        S_PCHK    = 15'h2000,
        S_EMIT    = 15'h4000
    } state_t;

    state_t                        state_reg, state_next;
    logic                          axis_reg, axis_next;
    logic                          ok_x_reg, ok_x_next;
    logic                          active_reg, active_next;
    logic                          out_valid_reg, out_valid_next;
    logic [LIMIT_WIDTH-1:0]        init_limit_reg, init_limit_next;
    logic [LIMIT_WIDTH-1:0]        run_limit_reg, run_limit_next;
    logic [STEP_WIDTH-1:0]         steps_reg, steps_next;
    logic [SHIFT_WIDTH-1:0]        shift_reg, shift_next;
    thr_t                          thr_reg, thr_next;
    thr_t                          nthr_reg, nthr_next;
    logic signed [COORD_WIDTH-1:0] cx_reg [4];
    logic signed [COORD_WIDTH-1:0] cx_next [4];
    logic signed [COORD_WIDTH-1:0] cy_reg [4];
    logic signed [COORD_WIDTH-1:0] cy_next [4];
    logic signed [COORD_WIDTH-1:0] ox_reg, ox_next;
    logic signed [COORD_WIDTH-1:0] oy_reg, oy_next;
    terms_t                        dx_reg, dx_next;
    terms_t                        dy_reg, dy_next;
    terms_t                        sx_reg, sx_next;
    terms_t                        sy_reg, sy_next;
    logic signed [FIELD_WIDTH-1:0] res_x_reg, res_x_next;
    logic signed [FIELD_WIDTH-1:0] res_y_reg, res_y_next;
    logic                          res_last_reg, res_last_next;
    logic signed [FIELD_WIDTH-1:0] out_x_reg, out_x_next;
    logic signed [FIELD_WIDTH-1:0] out_y_reg, out_y_next;
    logic                          out_last_reg, out_last_next;

    unit_ctrl_t                    unit_ctrl;
    terms_t                        unit_terms;
    terms_t                        unit_result;
    logic signed [COORD_WIDTH-1:0] unit_coord [4];
    logic signed [COORD_WIDTH-1:0] unit_origin;
    logic                          unit_within;

    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic [RND_WIDTH-1:0]          rnd_x;
    logic [RND_WIDTH-1:0]          rnd_y;
    logic [COORD_WIDTH-1:0]        px;
    logic [COORD_WIDTH-1:0]        py;
    thr_t                          lim_ext;
    logic                          main_wb;

    assign cfg.ready     = 1'b1;
    assign curve.ready   = (state_reg == S_IDLE);
    assign point.valid   = out_valid_reg;
    assign point.point_x = out_x_reg;
    assign point.point_y = out_y_reg;
    assign point.is_last = out_last_reg;

    cbf_term_unit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_term_unit (
        .ctrl     (unit_ctrl),
        .terms    (unit_terms),
        .coord    (unit_coord),
        .origin   (unit_origin),
        .thr      (thr_reg),
        .nthr     (nthr_reg),
        .result   (unit_result),
        .in_bound (unit_within)
    );

    // operand selection for the shared unit
    always_comb
    begin
        unit_ctrl.shift = shift_reg;
        case (state_reg)
            S_INIT:    unit_ctrl.op = OP_INIT;
            S_LAZY_A:  unit_ctrl.op = OP_LAZY_A;
            S_LAZY_B:  unit_ctrl.op = OP_LAZY_B;
            S_STEADY:  unit_ctrl.op = OP_STEADY;
            S_STEP:    unit_ctrl.op = OP_STEP;
            S_HALVE_A: unit_ctrl.op = OP_HALVE_A;
            S_HALVE_B: unit_ctrl.op = OP_HALVE_B;
            S_DOUBLE:  unit_ctrl.op = OP_DOUBLE;
            default:   unit_ctrl.op = OP_HOLD;
        endcase

        if (state_reg == S_PCHK)
        begin
            unit_terms = axis_reg ? sy_reg : sx_reg;
        end
        else
        begin
            unit_terms = axis_reg ? dy_reg : dx_reg;
        end

        for (int i = 0; i < 4; i++)
        begin
            unit_coord[i] = axis_reg ? cy_reg[i] : cx_reg[i];
        end
        unit_origin = axis_reg ? oy_reg : ox_reg;
    end

    // origin search and point rounding
    always_comb
    begin
        min_x = cx_reg[0];
        min_y = cy_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (cx_reg[i] < min_x)
            begin
                min_x = cx_reg[i];
            end
            if (cy_reg[i] < min_y)
            begin
                min_y = cy_reg[i];
            end
        end
        rnd_x = dx_reg.d0[RND_WIDTH-1:0] + RND_WIDTH'(ROUND_BIAS);
        rnd_y = dy_reg.d0[RND_WIDTH-1:0] + RND_WIDTH'(ROUND_BIAS);
        px = rnd_x[RND_WIDTH-1:POINT_FRAC] + $unsigned(ox_reg);
        py = rnd_y[RND_WIDTH-1:POINT_FRAC] + $unsigned(oy_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        axis_next       = axis_reg;
        ok_x_next       = ok_x_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg;
        init_limit_next = init_limit_reg;
        run_limit_next  = run_limit_reg;
        steps_next      = steps_reg;
        shift_next      = shift_reg;
        thr_next        = thr_reg;
        nthr_next       = nthr_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_last_next   = res_last_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_last_next   = out_last_reg;
        lim_ext         = '0;
        main_wb         = 1'b0;

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_INITIAL_LIMIT: init_limit_next = cfg.data;
                CFG_RUNNING_LIMIT: run_limit_next  = cfg.data;
                default: ;
            endcase
        end

        if (point.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                axis_next = 1'b0;
                if (curve.valid)
                begin
                    if (curve.action == ACTION_LOAD)
                    begin
                        cx_next[0]    = curve.p0_x[COORD_WIDTH-1:0];
                        cx_next[1]    = curve.p1_x[COORD_WIDTH-1:0];
                        cx_next[2]    = curve.p2_x[COORD_WIDTH-1:0];
                        cx_next[3]    = curve.p3_x[COORD_WIDTH-1:0];
                        cy_next[0]    = curve.p0_y[COORD_WIDTH-1:0];
                        cy_next[1]    = curve.p1_y[COORD_WIDTH-1:0];
                        cy_next[2]    = curve.p2_y[COORD_WIDTH-1:0];
                        cy_next[3]    = curve.p3_y[COORD_WIDTH-1:0];
                        res_x_next    = FIELD_WIDTH'($signed(curve.p0_x[COORD_WIDTH-1:0]));
                        res_y_next    = FIELD_WIDTH'($signed(curve.p0_y[COORD_WIDTH-1:0]));
                        res_last_next = 1'b0;
                        lim_ext       = thr_t'({1'b0, init_limit_reg});
                        thr_next      = lim_ext;
                        nthr_next     = -lim_ext;
                        shift_next    = '0;
                        steps_next    = STEP_WIDTH'(1);
                        active_next   = 1'b1;
                        state_next    = S_ORIGIN;
                    end
                    else if (active_reg)
                    begin
                        res_x_next = FIELD_WIDTH'($signed(px));
                        res_y_next = FIELD_WIDTH'($signed(py));
                        if (steps_reg == '0)
                        begin
                            res_last_next = 1'b1;
                            active_next   = 1'b0;
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            res_last_next = 1'b0;
                            lim_ext       = thr_t'({1'b0, run_limit_reg});
                            thr_next      = lim_ext;
                            nthr_next     = -lim_ext;
                            state_next    = S_RCHK;
                        end
                    end
                end
            end

            S_ORIGIN:
            begin
                ox_next    = min_x;
                oy_next    = min_y;
                state_next = S_INIT;
            end

            S_INIT, S_LAZY_A, S_LAZY_B, S_STEADY, S_STEP, S_HALVE_A, S_HALVE_B:
            begin
                main_wb = 1'b1;
                if (axis_reg)
                begin
                    axis_next = 1'b0;
                    case (state_reg)
                        S_INIT:    state_next = S_LCHK;
                        S_LAZY_A:  state_next = S_LAZY_B;
                        S_LAZY_B:  state_next = S_LCHK;
                        S_STEADY:  state_next = S_STEP;
                        S_HALVE_A: state_next = S_HALVE_B;
                        S_HALVE_B:
                        begin
                            steps_next = steps_reg << 1;
                            state_next = S_DTEST;
                        end
                        default:
                        begin
                            steps_next = steps_reg - STEP_WIDTH'(1);
                            state_next = S_EMIT;
                        end
                    endcase
                end
                else
                begin
                    axis_next = 1'b1;
                end
            end

            S_LCHK:
            begin
                if (!axis_reg)
                begin
                    ok_x_next = unit_within;
                    axis_next = 1'b1;
                end
                else
                begin
                    axis_next = 1'b0;
                    if ((ok_x_reg && unit_within) || shift_reg >= LAZY_SHIFT_MAX)
                    begin
                        state_next = S_STEADY;
                    end
                    else
                    begin
                        shift_next = shift_reg + LAZY_SHIFT_STEP;
                        thr_next   = thr_reg <<< LAZY_SHIFT_STEP;
                        nthr_next  = nthr_reg <<< LAZY_SHIFT_STEP;
                        steps_next = steps_reg << 1;
                        state_next = S_LAZY_A;
                    end
                end
            end

            S_RCHK:
            begin
                if (!axis_reg)
                begin
                    ok_x_next = unit_within;
                    axis_next = 1'b1;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = (ok_x_reg && unit_within) ? S_DTEST : S_HALVE_A;
                end
            end

            S_DTEST:
            begin
                axis_next = 1'b0;
                // double only on an even, non-zero step count
                if (steps_reg != '0 && !steps_reg[0])
                begin
                    state_next = S_DOUBLE;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end

            S_DOUBLE:
            begin
                if (axis_reg)
                begin
                    sy_next    = unit_result;
                    axis_next  = 1'b0;
                    state_next = S_PCHK;
                end
                else
                begin
                    sx_next   = unit_result;
                    axis_next = 1'b1;
                end
            end

            S_PCHK:
            begin
                if (!axis_reg)
                begin
                    ok_x_next = unit_within;
                    axis_next = 1'b1;
                end
                else
                begin
                    axis_next = 1'b0;
                    if (ok_x_reg && unit_within)
                    begin
                        // commit the doubled terms
                        dx_next    = sx_reg;
                        dy_next    = sy_reg;
                        steps_next = steps_reg >> 1;
                        state_next = S_DTEST;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || point.ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_last_next  = res_last_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (main_wb)
        begin
            if (axis_reg)
            begin
                dy_next = unit_result;
            end
            else
            begin
                dx_next = unit_result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            axis_reg       <= 1'b0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            init_limit_reg <= INITIAL_LIMIT_RESET;
            run_limit_reg  <= RUNNING_LIMIT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
            init_limit_reg <= init_limit_next;
            run_limit_reg  <= run_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_x_reg     <= ok_x_next;
        steps_reg    <= steps_next;
        shift_reg    <= shift_next;
        thr_reg      <= thr_next;
        nthr_reg     <= nthr_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_last_reg <= res_last_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: rtl/core/cbf_term_unit.sv
// Shared forward-difference unit: one operation on the four terms of one axis per cycle.
module cbf_term_unit #(
    parameter int COORD_WIDTH = cbf_pkg::COORD_WIDTH_DEFAULT
) (
    input  cbf_pkg::unit_ctrl_t           ctrl,
    input  cbf_pkg::terms_t               terms,
    input  logic signed [COORD_WIDTH-1:0] coord [4],
    input  logic signed [COORD_WIDTH-1:0] origin,
    input  cbf_pkg::thr_t                 thr,
    input  cbf_pkg::thr_t                 nthr,
    output cbf_pkg::terms_t               result,
    output logic                          in_bound
);
    import cbf_pkg::*;

    localparam int INIT_WIDTH = COORD_WIDTH + 5;

    term_t                        d0;
    term_t                        d1;
    term_t                        d2;
    term_t                        d3;
    term_t                        d2_new;
    logic signed [INIT_WIDTH-1:0] rel [4];
    logic signed [INIT_WIDTH-1:0] e_hi;
    logic signed [INIT_WIDTH-1:0] e_lo;
    logic signed [INIT_WIDTH-1:0] span;
    thr_t                         w2;
    thr_t                         w3;
    logic [SHIFT_WIDTH-1:0]       steady_amt;

    always_comb
    begin
        d0 = terms.d0;
        d1 = terms.d1;
        d2 = terms.d2;
        d3 = terms.d3;
        for (int i = 0; i < 4; i++)
        begin
            rel[i] = INIT_WIDTH'(coord[i]) - INIT_WIDTH'(origin);
        end
        e_hi = rel[1] - (rel[2] <<< 1) + rel[3];
        e_lo = rel[0] - (rel[1] <<< 1) + rel[2];
        span = rel[3] - rel[0];
        steady_amt = (ctrl.shift < STEADY_SHIFT) ? STEADY_SHIFT - ctrl.shift
                                                 : ctrl.shift - STEADY_SHIFT;
        d2_new = '0;
        result = terms;

        case (ctrl.op)
            OP_INIT:
            begin
                result.d0 = term_t'(rel[0]) <<< POS_SHIFT;
                result.d1 = term_t'(span) <<< POS_SHIFT;
                result.d2 = term_t'((e_hi <<< 1) + e_hi) <<< DIFF_SHIFT;
                result.d3 = term_t'((e_lo <<< 1) + e_lo) <<< DIFF_SHIFT;
            end
            OP_LAZY_A:
            begin
                d2_new    = d2 + d3;
                result.d2 = d2_new >>> 1;
            end
            OP_LAZY_B:
            begin
                // d2 already holds the halved value from the previous operation
                result.d1 = (d1 - (d2 >>> ctrl.shift)) >>> 1;
            end
            OP_STEADY:
            begin
                result.d0 = d0 <<< STEADY_SHIFT;
                result.d1 = d1 <<< STEADY_SHIFT;
                if (ctrl.shift < STEADY_SHIFT)
                begin
                    result.d2 = d2 <<< steady_amt;
                    result.d3 = d3 <<< steady_amt;
                end
                else
                begin
                    result.d2 = d2 >>> steady_amt;
                    result.d3 = d3 >>> steady_amt;
                end
            end
            OP_STEP:
            begin
                result.d0 = d0 + d1;
                result.d1 = d1 + d2;
                result.d2 = (d2 <<< 1) - d3;
                result.d3 = d2;
            end
            OP_HALVE_A:
            begin
                d2_new    = d2 + d3;
                result.d2 = d2_new >>> 3;
                result.d3 = d3 >>> 2;
            end
            OP_HALVE_B:
            begin
                result.d1 = (d1 - d2) >>> 1;
            end
            OP_DOUBLE:
            begin
                result.d1 = (d1 <<< 1) + d2;
                result.d3 = d3 <<< 2;
                result.d2 = (d2 <<< 3) - (d3 <<< 2);
            end
            default:
            begin
                result = terms;
            end
        endcase

        // magnitude test without negation: -thr <= v <= thr
        w2 = thr_t'(d2);
        w3 = thr_t'(d3);
        in_bound = (w2 <= thr) && (w2 >= nthr) && (w3 <= thr) && (w3 >= nthr);
    end

endmodule

FILE: rtl/core/cbf_checker.sv
// Port-level assertions for the cubic Bezier flattener, bound to its top level.
module cbf_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  curve_valid,
    input logic                                  curve_ready,
    input logic                                  curve_action,
    input logic                                  point_valid,
    input logic                                  point_ready,
    input logic signed [cbf_pkg::FIELD_WIDTH-1:0] point_x,
    input logic signed [cbf_pkg::FIELD_WIDTH-1:0] point_y,
    input logic                                  point_is_last
);
    import cbf_pkg::*;

    // after a load is accepted, the sequencer stays busy and refuses input
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        curve_valid && curve_ready && curve_action == ACTION_LOAD
        |=> !curve_ready ##1 !curve_ready ##1 !curve_ready)
        else $error("input accepted too soon after a load");

    // a new point only appears at the end of a busy stretch
    a_point_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(point_valid) |-> !$past(curve_ready))
        else $error("point offered without the sequencer having worked on it");

    a_point_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_ready
        |=> point_valid && $stable(point_x) && $stable(point_y) && $stable(point_is_last))
        else $error("stalled point item changed");

endmodule

bind cubic_bezier_flattener cbf_checker u_cbf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .curve_valid   (curve.valid),
    .curve_ready   (curve.ready),
    .curve_action  (curve.action),
    .point_valid   (point.valid),
    .point_ready   (point.ready),
    .point_x       (point.point_x),
    .point_y       (point.point_y),
    .point_is_last (point.is_last)
);

FILE: test/cubic_bezier_flattener_tb.sv
// Self-checking testbench for the cubic Bezier flattener: random curves against a bit-true predictor.
`timescale 1ns / 1ps

module cubic_bezier_flattener_tb;

    import cbf_pkg::*;

    localparam int COORD_W      = COORD_WIDTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef bit [3:0][63:0] diffs_t;

    typedef struct packed {
        bit        action;
        bit [15:0] p0_x;
        bit [15:0] p0_y;
        bit [15:0] p1_x;
        bit [15:0] p1_y;
        bit [15:0] p2_x;
        bit [15:0] p2_y;
        bit [15:0] p3_x;
        bit [15:0] p3_y;
    } curve_item_t;

    typedef struct packed {
        bit [15:0] x;
        bit [15:0] y;
        bit        last;
    } point_t;

    logic clk;
    logic rst_n;

    cbf_cfg_if   cfg_ch ();
    cbf_curve_if curve_ch ();
    cbf_point_if point_ch ();

    cubic_bezier_flattener dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .curve (curve_ch),
        .point (point_ch)
    );

    // predictor state
    diffs_t    x_terms;
    diffs_t    y_terms;
    bit [31:0] steps_to_go;
    bit [15:0] org_x;
    bit [15:0] org_y;
    bit        curve_live;
    bit [31:0] init_limit;
    bit [31:0] run_limit;

    curve_item_t pending_items[$];
    point_t      expected_points[$];
    curve_item_t next_item;

    int send_idle_pct;
    int recv_idle_pct;
    int queued_count;
    int failures;
    int cycle_count;
    int hold_left;
    bit pressure_armed;
    bit pressure_taken;

    function automatic bit [63:0] asr(bit [63:0] v, int unsigned s);
        return $signed(v) >>> (s & 63);
    endfunction

    function automatic bit [63:0] magnitude(bit [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic bit [63:0] term_err(diffs_t d);
        bit [63:0] a;
        bit [63:0] b;
        a = magnitude(d[2]);
        b = magnitude(d[3]);
        return (a > b) ? a : b;
    endfunction

    function automatic bit [63:0] parent_err(diffs_t d);
        bit [63:0] a;
        bit [63:0] b;
        a = d[3] << 2;
        b = (d[2] << 3) - a;
        a = magnitude(a);
        b = magnitude(b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint to_coord(bit [15:0] v);
        longint r;
        r = v & ((1 << COORD_W) - 1);
        if (r >= (longint'(1) << (COORD_W - 1)))
            r = r - (longint'(1) << COORD_W);
        return r;
    endfunction

    function automatic bit [15:0] coord_out(bit [63:0] v);
        longint c;
        c = to_coord(v[15:0]);
        return c[15:0];
    endfunction

    function automatic longint min_of4(longint a, longint b, longint c, longint d);
        longint m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        if (d < m) m = d;
        return m;
    endfunction

    function automatic diffs_t setup_axis(longint a0, longint a1, longint a2, longint a3);
        diffs_t d;
        d[0] = a0 << POS_SHIFT;
        d[1] = (a3 - a0) << POS_SHIFT;
        d[2] = (3 * (a1 - 2 * a2 + a3)) << DIFF_SHIFT;
        d[3] = (3 * (a0 - 2 * a1 + a2)) << DIFF_SHIFT;
        return d;
    endfunction

    function automatic diffs_t lazy_halve_axis(diffs_t d, int unsigned s);
        d[2] = asr(d[2] + d[3], 1);
        d[1] = asr(d[1] - asr(d[2], s), 1);
        return d;
    endfunction

    // move positions to 13 fraction bits and rescale the error terms to match
    function automatic diffs_t settle_axis(diffs_t d, int unsigned s);
        d[0] = d[0] << 3;
        d[1] = d[1] << 3;
        if (s < STEADY_SHIFT) begin
            d[2] = d[2] << (STEADY_SHIFT - s);
            d[3] = d[3] << (STEADY_SHIFT - s);
        end
        else begin
            d[2] = asr(d[2], s - STEADY_SHIFT);
            d[3] = asr(d[3], s - STEADY_SHIFT);
        end
        return d;
    endfunction

    function automatic diffs_t advance_axis(diffs_t d);
        bit [63:0] a;
        a = d[2];
        d[0] = d[0] + d[1];
        d[1] = d[1] + a;
        d[2] = d[2] + a - d[3];
        d[3] = a;
        return d;
    endfunction

    function automatic diffs_t halve_axis(diffs_t d);
        d[2] = asr(d[2] + d[3], 3);
        d[1] = asr(d[1] - d[2], 1);
        d[3] = asr(d[3], 2);
        return d;
    endfunction

    function automatic diffs_t double_axis(diffs_t d);
        d[1] = d[1] + d[1] + d[2];
        d[3] = d[3] << 2;
        d[2] = (d[2] << 3) - d[3];
        return d;
    endfunction

    task automatic flatten_item(input curve_item_t it, output bit emits, output point_t pt);
        longint      x0, x1, x2, x3, y0, y1, y2, y3, ox, oy;
        int unsigned shift;
        bit [63:0]   thr;
        bit [63:0]   lim;
        emits = 1'b0;
        pt = '0;
        if (it.action == ACTION_LOAD) begin
            x0 = to_coord(it.p0_x);
            y0 = to_coord(it.p0_y);
            x1 = to_coord(it.p1_x);
            y1 = to_coord(it.p1_y);
            x2 = to_coord(it.p2_x);
            y2 = to_coord(it.p2_y);
            x3 = to_coord(it.p3_x);
            y3 = to_coord(it.p3_y);
            ox = min_of4(x0, x1, x2, x3);
            oy = min_of4(y0, y1, y2, y3);
            org_x = ox[15:0];
            org_y = oy[15:0];
            x_terms = setup_axis(x0 - ox, x1 - ox, x2 - ox, x3 - ox);
            y_terms = setup_axis(y0 - oy, y1 - oy, y2 - oy, y3 - oy);
            steps_to_go = 32'd1;
            shift = 0;
            thr = {32'b0, init_limit};
            while (!(term_err(x_terms) <= thr && term_err(y_terms) <= thr)
                   && shift < LAZY_SHIFT_MAX) begin
                shift += LAZY_SHIFT_STEP;
                x_terms = lazy_halve_axis(x_terms, shift);
                y_terms = lazy_halve_axis(y_terms, shift);
                steps_to_go = steps_to_go << 1;
                thr = {32'b0, init_limit} << shift;
            end
            x_terms = advance_axis(settle_axis(x_terms, shift));
            y_terms = advance_axis(settle_axis(y_terms, shift));
            steps_to_go = steps_to_go - 1;
            curve_live = 1'b1;
            emits = 1'b1;
            pt.x = x0[15:0];
            pt.y = y0[15:0];
        end
        else if (curve_live) begin
            emits = 1'b1;
            pt.x = coord_out(asr(x_terms[0] + 64'(ROUND_BIAS), POINT_FRAC)
                             + {{48{org_x[15]}}, org_x});
            pt.y = coord_out(asr(y_terms[0] + 64'(ROUND_BIAS), POINT_FRAC)
                             + {{48{org_y[15]}}, org_y});
            if (steps_to_go == 0) begin
                pt.last = 1'b1;
                curve_live = 1'b0;
            end
            else begin
                lim = {32'b0, run_limit};
                if (term_err(x_terms) > lim || term_err(y_terms) > lim) begin
                    x_terms = halve_axis(x_terms);
                    y_terms = halve_axis(y_terms);
                    steps_to_go = steps_to_go << 1;
                end
                while (steps_to_go != 0 && !steps_to_go[0]
                       && parent_err(x_terms) <= lim && parent_err(y_terms) <= lim) begin
                    x_terms = double_axis(x_terms);
                    y_terms = double_axis(y_terms);
                    steps_to_go = steps_to_go >> 1;
                end
                x_terms = advance_axis(x_terms);
                y_terms = advance_axis(y_terms);
                steps_to_go = steps_to_go - 1;
            end
        end
    endtask

    function automatic curve_item_t load_item(bit [15:0] x0, bit [15:0] y0, bit [15:0] x1,
                                              bit [15:0] y1, bit [15:0] x2, bit [15:0] y2,
                                              bit [15:0] x3, bit [15:0] y3);
        curve_item_t it;
        it.action = ACTION_LOAD;
        it.p0_x = x0;
        it.p0_y = y0;
        it.p1_x = x1;
        it.p1_y = y1;
        it.p2_x = x2;
        it.p2_y = y2;
        it.p3_x = x3;
        it.p3_y = y3;
        return it;
    endfunction

    // point fields are ignored on a step, so fill them with noise
    function automatic curve_item_t step_item();
        curve_item_t it;
        it = load_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        it.action = ACTION_STEP;
        return it;
    endfunction

    function automatic bit [15:0] extreme();
        return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endfunction

    task automatic push_item(input curve_item_t it, output bit ended);
        bit     emits;
        point_t pt;
        flatten_item(it, emits, pt);
        pending_items.push_back(it);
        if (emits) begin
            expected_points.push_back(pt);
            queued_count++;
        end
        ended = emits && pt.last;
    endtask

    task automatic queue_steps(input int cap, output bit ended);
        ended = 1'b0;
        for (int k = 0; k < cap && !ended; k++)
            push_item(step_item(), ended);
    endtask

    task automatic queue_curve(input int step_cap);
        int        cls;
        int        spread;
        int        cap;
        bit [15:0] bx;
        bit [15:0] by;
        bit [15:0] c[8];
        bit        ended;
        cls = $urandom_range(99);
        spread = (cls < 75) ? 256 : ((cls < 95) ? 4096 : 65536);
        bx = 16'($urandom);
        by = 16'($urandom);
        for (int i = 0; i < 8; i++) begin
            if (spread == 65536)
                c[i] = 16'($urandom);
            else
                c[i] = ((i % 2 == 0) ? bx : by) + 16'($urandom_range(spread - 1));
        end
        push_item(load_item(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]), ended);
        cap = $urandom_range(1, step_cap);
        // cut some curves short so the next load drops them
        if ($urandom_range(99) < 10)
            cap = $urandom_range(1, 4);
        queue_steps(cap, ended);
        if (ended && $urandom_range(99) < 8)
            push_item(step_item(), ended);
    endtask

    task automatic settle_block();
        while (pending_items.size() != 0 || curve_ch.valid || expected_points.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_limit(input logic [CFG_INDEX_WIDTH-1:0] idx, input bit [31:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_INITIAL_LIMIT)
            init_limit = value;
        else
            run_limit = value;
    endtask

    task automatic run_phase(input bit [31:0] init_val, input bit [31:0] run_val,
                             input int send_pct, input int recv_pct, input int target,
                             input int step_cap, input bit pressure);
        bit ended;
        settle_block();
        set_limit(CFG_INITIAL_LIMIT, init_val);
        set_limit(CFG_RUNNING_LIMIT, run_val);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (pressure)
            pressure_armed = 1'b1;
        push_item(load_item(extreme(), extreme(), extreme(), extreme(),
                            extreme(), extreme(), extreme(), extreme()), ended);
        queue_steps(3, ended);
        queued_count = 0;
        // keep the last curve within what the phase still needs
        while (queued_count < target)
            queue_curve((target - queued_count < step_cap) ? target - queued_count : step_cap);
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        $error("%s mismatch: expected %0d, got %0d", field, $signed(want), $signed(got));
        failures++;
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL cubic_bezier_flattener");
            $finish;
        end
    end

    // sender: hold an item until it is taken, then offer the next or idle
    always @(posedge clk) begin
        if (rst_n && (!curve_ch.valid || curve_ch.ready)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_items.pop_front();
                curve_ch.valid  <= 1'b1;
                curve_ch.action <= next_item.action;
                curve_ch.p0_x   <= next_item.p0_x;
                curve_ch.p0_y   <= next_item.p0_y;
                curve_ch.p1_x   <= next_item.p1_x;
                curve_ch.p1_y   <= next_item.p1_y;
                curve_ch.p2_x   <= next_item.p2_x;
                curve_ch.p2_y   <= next_item.p2_y;
                curve_ch.p3_x   <= next_item.p3_x;
                curve_ch.p3_y   <= next_item.p3_y;
            end
            else begin
                curve_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge clk) begin
        if (!rst_n) begin
            point_ch.ready <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            point_ch.ready <= 1'b0;
        end
        else if (pressure_armed && !pressure_taken) begin
            pressure_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            point_ch.ready <= 1'b0;
        end
        else begin
            point_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        point_t want;
        if (rst_n && point_ch.valid && point_ch.ready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point (%0d, %0d) last %0b", point_ch.point_x,
                       point_ch.point_y, point_ch.is_last);
                failures++;
            end
            else begin
                want = expected_points.pop_front();
                if (point_ch.point_x !== want.x)
                    report_mismatch("point_x", want.x, point_ch.point_x);
                if (point_ch.point_y !== want.y)
                    report_mismatch("point_y", want.y, point_ch.point_y);
                if (point_ch.is_last !== want.last)
                    report_mismatch("is_last", {15'b0, want.last}, {15'b0, point_ch.is_last});
            end
        end
    end

    initial begin
        bit ended;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_INITIAL_LIMIT;
        cfg_ch.data = '0;
        curve_ch.valid = 1'b0;
        curve_ch.action = ACTION_LOAD;
        curve_ch.p0_x = '0;
        curve_ch.p0_y = '0;
        curve_ch.p1_x = '0;
        curve_ch.p1_y = '0;
        curve_ch.p2_x = '0;
        curve_ch.p2_y = '0;
        curve_ch.p3_x = '0;
        curve_ch.p3_y = '0;
        point_ch.ready = 1'b0;
        failures = 0;
        cycle_count = 0;
        hold_left = 0;
        pressure_armed = 1'b0;
        pressure_taken = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 83;
        x_terms = '0;
        y_terms = '0;
        steps_to_go = '0;
        org_x = '0;
        org_y = '0;
        curve_live = 1'b0;
        init_limit = INITIAL_LIMIT_RESET;
        run_limit = RUNNING_LIMIT_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // step before any load: nothing comes back
        push_item(step_item(), ended);
        // flat curve at the negative corner: one step reaches the end point
        push_item(load_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000), ended);
        queue_steps(3, ended);
        push_item(step_item(), ended);
        push_item(load_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), ended);
        queue_steps(2, ended);
        // full-range curve, then reload before it ends
        push_item(load_item(16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                            16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF), ended);
        queue_steps(4, ended);
        push_item(load_item(16'd0, 16'd0, 16'd40, 16'd100,
                            16'd80, -16'sd100, 16'd120, 16'd0), ended);
        queue_steps(12, ended);
        push_item(step_item(), ended);
        push_item(load_item(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000), ended);
        queue_steps(3, ended);

        run_phase(32'd1, 32'hFFFF_FFFF, 24, 83, 300, 150, 1'b0);
        run_phase($urandom_range(1000, 60000), 32'd1, 24, 83, 250, 80, 1'b0);
        run_phase(32'hFFFF_FFFF, $urandom_range(1, 1 << 22), 83, 24, 150, 150, 1'b0);
        run_phase($urandom_range(1, 1 << 20), $urandom_range(1, 1 << 22), 83, 24, 300, 150,
                  1'b0);
        run_phase(INITIAL_LIMIT_RESET, RUNNING_LIMIT_RESET, 0, 0, 300, 150, 1'b1);
        run_phase($urandom | 32'd1, $urandom | 32'd1, 0, 0, 250, 150, 1'b0);

        settle_block();
        if (failures == 0 && expected_points.size() == 0)
            $display("PASS cubic_bezier_flattener");
        else
            $display("FAIL cubic_bezier_flattener");
        $finish;
    end

endmodule
